>>> rtl/bfbs_pkg.sv
// shared constants and types for the best fit block search
`timescale 1ns / 1ps
`default_nettype none

package bfbs_pkg;

    // default table depth and block size width
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths of the request and result channels
    localparam int IDX_BITS = 6;
    localparam int CNT_BITS = 7;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request kinds
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_REQ  = 1'b1
    } t_op;

endpackage

`default_nettype wire

>>> rtl/bfbs_if.sv
// request and result channel interfaces of the best fit block search
`timescale 1ns / 1ps
`default_nettype none

interface bfbs_in_if #(
    parameter int SIZE_BITS = bfbs_pkg::SIZE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [bfbs_pkg::IDX_BITS-1:0] block_index;
    logic [SIZE_BITS-1:0]          size_value;

    modport source (output valid, kind, block_index, size_value, input ready);
    modport sink   (input valid, kind, block_index, size_value, output ready);
endinterface

interface bfbs_out_if #(
    parameter int SIZE_BITS = bfbs_pkg::SIZE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [bfbs_pkg::IDX_BITS-1:0] chosen_block;
    logic [SIZE_BITS-1:0]          chosen_size;
    logic [SIZE_BITS-1:0]          fragment;

    modport source (output valid, found, chosen_block, chosen_size, fragment, input ready);
    modport sink   (input valid, found, chosen_block, chosen_size, fragment, output ready);
endinterface

`default_nettype wire

>>> rtl/bfbs_front.sv
// front end: accepts requests, drops out of range loads, queues commands
`timescale 1ns / 1ps
`default_nettype none

module bfbs_front #(
    parameter int MAX_BLOCKS = bfbs_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = bfbs_pkg::SIZE_BITS_DEF,
    parameter int ADDR_W     = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bfbs_in_if.sink                   i_in,
    output      logic                 o_cmd_valid,
    output      bfbs_pkg::t_op        o_cmd_op,
    output      logic [ADDR_W-1:0]    o_cmd_addr,
    output      logic [SIZE_BITS-1:0] o_cmd_size,
    input  wire logic                 i_cmd_pop
);
    import bfbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op                  r_q_op   [QUEUE_DEPTH];
    logic [ADDR_W-1:0]    r_q_addr [QUEUE_DEPTH];
    logic [SIZE_BITS-1:0] r_q_size [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]    r_count, n_count;

    logic accept;
    logic keep;
    logic push;
    logic pop;

    // classify: requests always go on, loads only with an index inside the table
    assign i_in.ready = (r_count < QCNT_W'(QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign keep       = (t_op'(i_in.kind) == OP_REQ) || (32'(i_in.block_index) < MAX_BLOCKS);
    assign push       = accept && keep;
    assign pop        = i_cmd_pop && (r_count != '0);

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wr_ptr]   <= t_op'(i_in.kind);
            r_q_addr[r_wr_ptr] <= ADDR_W'(i_in.block_index);
            r_q_size[r_wr_ptr] <= i_in.size_value;
        end
    end

    // head of the queue
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd_op    = r_q_op[r_rd_ptr];
    assign o_cmd_addr  = r_q_addr[r_rd_ptr];
    assign o_cmd_size  = r_q_size[r_rd_ptr];

endmodule

`default_nettype wire

>>> rtl/bfbs_back.sv
// back end: block size table, sequential best fit scan and result register
`timescale 1ns / 1ps
`default_nettype none

module bfbs_back #(
    parameter int MAX_BLOCKS = bfbs_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = bfbs_pkg::SIZE_BITS_DEF,
    parameter int ADDR_W     = 6,
    parameter int LIM_W      = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire bfbs_pkg::t_op                 i_cmd_op,
    input  wire logic [ADDR_W-1:0]             i_cmd_addr,
    input  wire logic [SIZE_BITS-1:0]          i_cmd_size,
    output      logic                          o_cmd_pop,
    input  wire logic [bfbs_pkg::CNT_BITS-1:0] i_block_count,
    bfbs_out_if.source                         o_out
);
    import bfbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SIZE_BITS-1:0] r_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] r_rd_data;

    logic [LIM_W-1:0]     r_limit, n_limit;
    logic [LIM_W-1:0]     r_issue, n_issue;
    logic                 r_pend, n_pend;
    logic [ADDR_W-1:0]    r_pend_idx, n_pend_idx;
    logic [SIZE_BITS-1:0] r_req_size, n_req_size;
    logic                 r_have, n_have;
    logic [SIZE_BITS-1:0] r_best_size, n_best_size;
    logic [ADDR_W-1:0]    r_best_idx, n_best_idx;

    logic                 r_out_valid, n_out_valid;
    logic                 r_found, n_found;
    logic [IDX_BITS-1:0]  r_chosen_block, n_chosen_block;
    logic [SIZE_BITS-1:0] r_chosen_size, n_chosen_size;
    logic [SIZE_BITS-1:0] r_fragment, n_fragment;

    logic             out_free;
    logic [LIM_W-1:0] cfg_limit;
    logic             better;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign out_free  = !r_out_valid || o_out.ready;

    // search limit saturated to the table depth
    assign cfg_limit = (32'(i_block_count) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS)
                                                         : LIM_W'(i_block_count);

    // candidate beats the best so far, ties keep the lower index
    assign better = r_pend && (r_rd_data >= r_req_size)
                    && (!r_have || (r_rd_data < r_best_size));

    // table write on loads, registered read for the scan
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd_op == OP_LOAD)) begin
            r_mem[i_cmd_addr] <= i_cmd_size;
        end
        r_rd_data <= r_mem[r_issue[ADDR_W-1:0]];
    end

    // scan sequencer
    always_comb begin
        n_state        = r_state;
        n_limit        = r_limit;
        n_issue        = r_issue;
        n_pend         = r_pend;
        n_pend_idx     = r_pend_idx;
        n_req_size     = r_req_size;
        n_have         = r_have;
        n_best_size    = r_best_size;
        n_best_idx     = r_best_idx;
        n_out_valid    = r_out_valid;
        n_found        = r_found;
        n_chosen_block = r_chosen_block;
        n_chosen_size  = r_chosen_size;
        n_fragment     = r_fragment;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (i_cmd_op == OP_REQ)) begin
                    n_state     = S_SCAN;
                    n_limit     = cfg_limit;
                    n_issue     = '0;
                    n_pend      = 1'b0;
                    n_req_size  = i_cmd_size;
                    n_have      = 1'b0;
                    n_best_size = '0;
                    n_best_idx  = '0;
                end
            end
            S_SCAN: begin
                // issue one table read per cycle
                if (r_issue < r_limit) begin
                    n_issue    = r_issue + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[ADDR_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                // compare the entry read last cycle
                if (better) begin
                    n_have      = 1'b1;
                    n_best_size = r_rd_data;
                    n_best_idx  = r_pend_idx;
                end
                if (!r_pend && (r_issue == r_limit)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the answer to the result register
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_found        = r_have;
                    n_chosen_block = r_have ? IDX_BITS'(r_best_idx) : '0;
                    n_chosen_size  = r_have ? r_best_size : '0;
                    n_fragment     = r_have ? (r_best_size - r_req_size) : '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_limit        <= n_limit;
        r_pend_idx     <= n_pend_idx;
        r_req_size     <= n_req_size;
        r_best_size    <= n_best_size;
        r_best_idx     <= n_best_idx;
        r_found        <= n_found;
        r_chosen_block <= n_chosen_block;
        r_chosen_size  <= n_chosen_size;
        r_fragment     <= n_fragment;
    end

    // result channel
    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.chosen_block = r_chosen_block;
    assign o_out.chosen_size  = r_chosen_size;
    assign o_out.fragment     = r_fragment;

`ifndef ASSERT_OFF
    // a pending read only exists while scanning
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> !r_pend)
        else $error("pending table read outside of scan");

    // a pending read always targets an entry below the search limit
    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (LIM_W'(r_pend_idx) < r_limit))
        else $error("scan read beyond search limit");

    // the best block so far always fits the request
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_have) |-> (r_best_size >= r_req_size))
        else $error("best block smaller than request");
`endif

endmodule

`default_nettype wire

>>> rtl/best_fit_block_search.sv
// Best fit block search top level: table of block sizes with a best fit scan.
// Load request: written into the table as the back end pops it, no result.
// Search request: one-entry-per-cycle table scan over block_count entries,
// count saturated to MAX_BLOCKS, then the answer goes to the result register.
// The back end takes no new command until the previous answer has been handed on.
// Synchronous active-low reset clears block_count, queue and control; table undefined.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_block_search #(
    parameter int MAX_BLOCKS = bfbs_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = bfbs_pkg::SIZE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bfbs_in_if.sink                            i_in,
    bfbs_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [bfbs_pkg::CNT_BITS-1:0] i_cfg_wdata
);
    import bfbs_pkg::*;

    localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LIM_W  = $clog2(MAX_BLOCKS + 1);

    logic [CNT_BITS-1:0]  r_block_count;

    logic                 cmd_valid;
    t_op                  cmd_op;
    logic [ADDR_W-1:0]    cmd_addr;
    logic [SIZE_BITS-1:0] cmd_size;
    logic                 cmd_pop;

    // block count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_wdata;
        end
    end

    // request intake and command queue
    bfbs_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd_op    (cmd_op),
        .o_cmd_addr  (cmd_addr),
        .o_cmd_size  (cmd_size),
        .i_cmd_pop   (cmd_pop)
    );

    // table, scan and result
    bfbs_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .ADDR_W     (ADDR_W),
        .LIM_W      (LIM_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd_op      (cmd_op),
        .i_cmd_addr    (cmd_addr),
        .i_cmd_size    (cmd_size),
        .o_cmd_pop     (cmd_pop),
        .i_block_count (r_block_count),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

>>> verif/tb_best_fit_block_search.sv
// testbench for the best fit block search: table loads, best fit requests and checking
`timescale 1ns / 1ps

module tb_best_fit_block_search;

    import bfbs_pkg::*;

    localparam int MAX_BLOCKS    = MAX_BLOCKS_DEF;
    localparam int SIZE_BITS     = SIZE_BITS_DEF;
    localparam int SETTLE_CYCLES = MAX_BLOCKS + 16;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        t_op                 kind;
        logic [IDX_BITS-1:0] block_index;
        logic [SIZE_BITS-1:0] size_value;
    } block_cmd_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  chosen_block;
        logic [SIZE_BITS-1:0] chosen_size;
        logic [SIZE_BITS-1:0] fragment;
    } fit_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CNT_BITS-1:0] cfg_wdata;

    bfbs_in_if  #(.SIZE_BITS(SIZE_BITS)) in_if ();
    bfbs_out_if #(.SIZE_BITS(SIZE_BITS)) out_if ();

    best_fit_block_search #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // requests waiting to be sent and fit answers waiting to arrive
    block_cmd_t  block_cmds[$];
    fit_result_t expected_fits[$];

    // predictor copy of the partition table and the block count
    logic [SIZE_BITS-1:0] part_sizes [MAX_BLOCKS];
    logic [CNT_BITS-1:0]  part_count;

    // stimulus planning state
    logic [MAX_BLOCKS-1:0] loaded_mask;
    int unsigned           plan_count;

    // pacing controls
    logic        src_idle_en;
    logic        snk_idle_en;
    logic        long_hold_tog;
    logic        long_hold_seen;
    int unsigned long_hold_left;
    int unsigned src_gap;
    int unsigned snk_gap;
    int unsigned mismatches;
    int unsigned cycle_cnt;

    // smallest fitting block among the searched entries, lowest index on ties
    function automatic fit_result_t best_fit_for(logic [SIZE_BITS-1:0] want);
        fit_result_t r;
        int          lim;
        r   = '0;
        lim = (part_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(part_count);
        for (int i = 0; i < lim; i++) begin
            if (part_sizes[i] >= want && (!r.found || part_sizes[i] < r.chosen_size)) begin
                r.found        = 1'b1;
                r.chosen_block = IDX_BITS'(i);
                r.chosen_size  = part_sizes[i];
            end
        end
        if (r.found)
            r.fragment = r.chosen_size - want;
        return r;
    endfunction

    // apply an accepted request to the predictor
    task automatic absorb_cmd(block_cmd_t cmd);
        if (cmd.kind == OP_LOAD) begin
            part_sizes[cmd.block_index] = cmd.size_value;
        end else begin
            expected_fits.push_back(best_fit_for(cmd.size_value));
        end
    endtask

    // sizes biased to a small range so ties and exact fits are common
    function automatic logic [SIZE_BITS-1:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return SIZE_BITS'($urandom_range(0, 31));
        else if (sel < 85)
            return {SIZE_BITS{1'b1}} - SIZE_BITS'($urandom_range(0, 15));
        else
            return SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1));
    endfunction

    task automatic push_load(int unsigned idx, logic [SIZE_BITS-1:0] sz);
        block_cmd_t cmd;
        cmd.kind        = OP_LOAD;
        cmd.block_index = IDX_BITS'(idx);
        cmd.size_value  = sz;
        block_cmds.push_back(cmd);
        loaded_mask[idx] = 1'b1;
    endtask

    // a search never reaches an entry that was never loaded
    task automatic push_search(int unsigned idx, logic [SIZE_BITS-1:0] sz);
        block_cmd_t cmd;
        int unsigned lim;
        lim = (plan_count > MAX_BLOCKS) ? MAX_BLOCKS : plan_count;
        for (int unsigned i = 0; i < lim; i++)
            if (!loaded_mask[i])
                push_load(i, pick_size());
        cmd.kind        = OP_REQ;
        cmd.block_index = IDX_BITS'(idx);
        cmd.size_value  = sz;
        block_cmds.push_back(cmd);
    endtask

    // wait until everything is sent and every answer is back
    task automatic drain();
        while (block_cmds.size() != 0 || expected_fits.size() != 0)
            @(posedge i_clk);
    endtask

    // block count write, only with the block idle
    task automatic set_count(logic [CNT_BITS-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        part_count  = value;
        plan_count  = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // mixed loads and searches, loads mostly into the searched range
    task automatic queue_random(int unsigned n, int unsigned search_pct);
        int unsigned span;
        int unsigned idx;
        span = (plan_count == 0) ? 1 : ((plan_count > MAX_BLOCKS) ? MAX_BLOCKS : plan_count);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < search_pct) begin
                push_search($urandom_range(0, MAX_BLOCKS - 1), pick_size());
            end else begin
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_BLOCKS - 1)
                                                  : $urandom_range(0, span - 1);
                push_load(idx, pick_size());
            end
        end
    endtask

    task automatic set_idling(logic src_on, logic snk_on);
        @(posedge i_clk);
        src_idle_en <= src_on;
        snk_idle_en <= snk_on;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_gap     = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                absorb_cmd(block_cmds[0]);
                void'(block_cmds.pop_front());
                if (src_idle_en && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 18);
            end
            if (in_if.valid && !in_if.ready) begin
                in_if.valid <= 1'b1;
            end else if (src_gap != 0) begin
                src_gap--;
                in_if.valid <= 1'b0;
            end else if (block_cmds.size() != 0) begin
                in_if.valid       <= 1'b1;
                in_if.kind        <= block_cmds[0].kind;
                in_if.block_index <= block_cmds[0].block_index;
                in_if.size_value  <= block_cmds[0].size_value;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // answer monitor and receiver pacing
    always @(posedge i_clk) begin
        fit_result_t want;
        fit_result_t got;
        if (!i_rst_n) begin
            out_if.ready   <= 1'b0;
            snk_gap        = 0;
            long_hold_left = 0;
            long_hold_seen = long_hold_tog;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.found        = out_if.found;
                got.chosen_block = out_if.chosen_block;
                got.chosen_size  = out_if.chosen_size;
                got.fragment     = out_if.fragment;
                if (expected_fits.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected answer: expected none, got found=%0d block=%0d size=%0d frag=%0d",
                             $time, got.found, got.chosen_block, got.chosen_size, got.fragment);
                end else begin
                    want = expected_fits.pop_front();
                    if (got.found !== want.found || got.chosen_block !== want.chosen_block ||
                        got.chosen_size !== want.chosen_size || got.fragment !== want.fragment) begin
                        mismatches++;
                        $display("%0t answer mismatch: expected found=%0d block=%0d size=%0d frag=%0d, got found=%0d block=%0d size=%0d frag=%0d",
                                 $time, want.found, want.chosen_block, want.chosen_size,
                                 want.fragment, got.found, got.chosen_block, got.chosen_size,
                                 got.fragment);
                    end
                end
            end
            if (long_hold_tog != long_hold_seen) begin
                long_hold_seen = long_hold_tog;
                long_hold_left = LONG_HOLD;
            end
            if (long_hold_left != 0) begin
                long_hold_left--;
                out_if.ready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(1, 18) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_if.valid       = 1'b0;
        in_if.kind        = OP_LOAD;
        in_if.block_index = '0;
        in_if.size_value  = '0;
        out_if.ready      = 1'b0;
        src_idle_en       = 1'b1;
        snk_idle_en       = 1'b1;
        long_hold_tog     = 1'b0;
        long_hold_seen    = 1'b0;
        mismatches        = 0;
        cycle_cnt         = 0;
        loaded_mask       = '0;
        plan_count        = 0;
        part_count        = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
            part_sizes[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset, then load a small table with a tie
        push_search(MAX_BLOCKS - 1, '0);
        push_search(0, '1);
        push_load(0, '1);
        push_load(MAX_BLOCKS - 1, '0);
        push_load(1, 16'd100);
        push_load(2, 16'd40);
        push_load(3, 16'd40);
        push_load(4, '0);
        push_search(42, '0);

        // exact fit, tie, zero size, largest size, not found
        set_count(CNT_BITS'(5));
        push_search(0, 16'd40);
        push_search(MAX_BLOCKS - 1, 16'd41);
        push_search(21, '0);
        push_search(0, '1);
        push_search(5, 16'd101);
        push_load(0, 16'd50);
        push_search(0, 16'd101);
        push_search(0, 16'd100);

        // count above the table depth
        set_count('1);
        push_search(0, '0);
        push_search(MAX_BLOCKS - 1, '1);
        push_search(0, 16'd20);

        set_count(CNT_BITS'(1));
        queue_random(60, 50);
        set_count(CNT_BITS'(MAX_BLOCKS));
        queue_random(80, 50);
        set_count('0);
        queue_random(30, 60);

        // receiver holds off while the sender keeps offering
        set_count(CNT_BITS'(2));
        set_idling(1'b0, 1'b0);
        queue_random(60, 80);
        @(posedge i_clk);
        long_hold_tog <= ~long_hold_tog;
        drain();
        set_idling(1'b1, 1'b1);
        queue_random(40, 50);

        // random counts, with a sender pause in the middle of each
        repeat (5) begin
            set_count(CNT_BITS'($urandom_range(0, (1 << CNT_BITS) - 1)));
            queue_random(40, 50);
            drain();
            queue_random(40, 50);
        end

        // closing stretch without idling
        set_count(CNT_BITS'($urandom_range(1, 16)));
        set_idling(1'b0, 1'b0);
        queue_random(100, 50);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
